// File: hw/rtl/sde_pkg.sv
package sde_pkg;

   // Microprogram step address
   typedef logic [2:0] step_type;

   localparam step_type STEP_ATK_MUL  = 3'd0;
   localparam step_type STEP_ATK_ADD  = 3'd1;
   localparam step_type STEP_REL_MUL  = 3'd2;
   localparam step_type STEP_REL_SUB  = 3'd3;
   localparam step_type STEP_GAIN_MUL = 3'd4;
   localparam step_type STEP_GAIN_SUB = 3'd5;
   localparam step_type STEP_OUT_MUL  = 3'd6;
   localparam step_type STEP_OUT_WR   = 3'd7;

   // Configuration register indexes
   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_ATTACK_COEFF  = 2'd0;
   localparam csr_index_type CSR_RELEASE_COEFF = 2'd1;
   localparam csr_index_type CSR_DUCK_DEPTH    = 2'd2;

   // Multiplier operand pairs
   typedef enum logic [1:0] {
      MUL_ATTACK,
      MUL_RELEASE,
      MUL_DEPTH,
      MUL_SAMPLE
   } mul_sel_type;

   // Post-multiply operations
   typedef enum logic [2:0] {
      ALU_NONE,
      ALU_ENV_ADD,
      ALU_ENV_SUB,
      ALU_GAIN,
      ALU_OUT
   } alu_op_type;

   // Sequencer branch kinds
   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_CNT_ZERO
   } jump_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // One microcode word
   typedef struct packed {
      mul_sel_type mul_sel;
      alu_op_type  alu_op;
      jump_type    jump;
      step_type    target;
      logic        cnt_dec;
      logic        last;
   } ucode_word_type;

   // Sequencer to datapath control
   typedef struct packed {
      logic        item_load;
      logic        exec;
      mul_sel_type mul_sel;
      alu_op_type  alu_op;
   } dp_ctrl_type;

   // Control store: attack loop, release, gain, output
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      w = '{MUL_ATTACK, ALU_NONE, JMP_NEXT, STEP_ATK_MUL, 1'b0, 1'b0};
      unique case (step)
         STEP_ATK_MUL:  w = '{MUL_ATTACK, ALU_NONE, JMP_CNT_ZERO, STEP_REL_MUL, 1'b0, 1'b0};
         STEP_ATK_ADD:  w = '{MUL_ATTACK, ALU_ENV_ADD, JMP_ALWAYS, STEP_ATK_MUL, 1'b1, 1'b0};
         STEP_REL_MUL:  w = '{MUL_RELEASE, ALU_NONE, JMP_NEXT, STEP_ATK_MUL, 1'b0, 1'b0};
         STEP_REL_SUB:  w = '{MUL_RELEASE, ALU_ENV_SUB, JMP_NEXT, STEP_ATK_MUL, 1'b0, 1'b0};
         STEP_GAIN_MUL: w = '{MUL_DEPTH, ALU_NONE, JMP_NEXT, STEP_ATK_MUL, 1'b0, 1'b0};
         STEP_GAIN_SUB: w = '{MUL_DEPTH, ALU_GAIN, JMP_NEXT, STEP_ATK_MUL, 1'b0, 1'b0};
         STEP_OUT_MUL:  w = '{MUL_SAMPLE, ALU_NONE, JMP_NEXT, STEP_ATK_MUL, 1'b0, 1'b0};
         STEP_OUT_WR:   w = '{MUL_SAMPLE, ALU_OUT, JMP_ALWAYS, STEP_ATK_MUL, 1'b0, 1'b1};
         default:       w = '{MUL_ATTACK, ALU_NONE, JMP_NEXT, STEP_ATK_MUL, 1'b0, 1'b0};
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/sde_ucode_seq.sv
module sde_ucode_seq
   import sde_pkg::*;
#(
   parameter int MAX_TRIGGERS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_trigger_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dp_ctrl_type dp_ctrl
);

   // Trigger count saturates at the configured maximum
   localparam int CapTrig = (MAX_TRIGGERS < 3) ? MAX_TRIGGERS : 3;
   localparam logic [1:0] CapTrigQ = 2'(CapTrig);

   seq_state_type  state_ff, state_in;
   step_type       step_ff, step_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   ucode_word_type word;
   logic           item_accept;
   logic           waiting;
   logic           exec;
   logic [1:0]     trig_capped;

   assign word        = ucode_rom(step_ff);
   assign item_accept = req_valid && !req_stall;
   assign waiting     = (state_ff == SEQ_RUN) && word.last && rsp_valid_ff && rsp_stall;
   assign exec        = (state_ff == SEQ_RUN) && !waiting;
   assign trig_capped = (req_trigger_count > CapTrigQ) ? CapTrigQ : req_trigger_count;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: if (req_valid) state_in = SEQ_RUN;
         SEQ_RUN:  if (exec && word.last) state_in = SEQ_IDLE;
         default:  state_in = SEQ_IDLE;
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      req_stall = 1'b1;
      unique case (state_ff)
         SEQ_IDLE: req_stall = 1'b0;
         SEQ_RUN:  req_stall = 1'b1;
         default:  req_stall = 1'b1;
      endcase
   end

   // Step counter and loop counter
   always_comb begin
      step_in = step_ff;
      cnt_in  = cnt_ff;
      if (item_accept) begin
         step_in = STEP_ATK_MUL;
         cnt_in  = trig_capped;
      end else if (exec) begin
         if (word.cnt_dec) cnt_in = cnt_ff - 2'd1;
         case (word.jump)
            JMP_NEXT:     step_in = step_ff + 3'd1;
            JMP_ALWAYS:   step_in = word.target;
            JMP_CNT_ZERO: step_in = (cnt_ff == 2'd0) ? word.target : step_ff + 3'd1;
            default:      step_in = step_ff + 3'd1;
         endcase
      end
   end

   // Result beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (exec && word.last) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         step_ff      <= STEP_ATK_MUL;
         cnt_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign dp_ctrl.item_load = item_accept;
   assign dp_ctrl.exec      = exec;
   assign dp_ctrl.mul_sel   = word.mul_sel;
   assign dp_ctrl.alu_op    = word.alu_op;

`ifndef NO_ASSERTIONS
   a_done_gives_beat: assert property (@(posedge clock) disable iff (reset)
      (exec && word.last) |=> rsp_valid_ff)
      else $error("finished item did not raise result valid");

   a_no_count_underflow: assert property (@(posedge clock) disable iff (reset)
      (exec && word.cnt_dec) |-> (cnt_ff != 2'd0))
      else $error("trigger loop ran past zero");

   a_wait_holds_step: assert property (@(posedge clock) disable iff (reset)
      waiting |=> (step_ff == $past(step_ff)))
      else $error("step moved while output was blocked");
`endif

endmodule

// File: hw/rtl/sde_datapath.sv
module sde_datapath
   import sde_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_ctrl_type               dp_ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic [FRAC_BITS:0]        attack_coeff,
   input  logic [FRAC_BITS:0]        release_coeff,
   input  logic [FRAC_BITS:0]        duck_depth,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_ducked_sample,
   output logic [FRAC_BITS:0]        rsp_envelope_level
);

   localparam int CW = FRAC_BITS + 1;
   localparam int SW = SAMPLE_WIDTH;
   localparam int AW = (CW > SW) ? CW : SW;
   localparam int PW = AW + CW;
   localparam logic [CW-1:0] OneQ = {1'b1, {FRAC_BITS{1'b0}}};

   logic [CW-1:0] env_ff, env_in;
   logic [CW-1:0] gain_ff, gain_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [SW-1:0] mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic [SW-1:0] out_sample_ff, out_sample_in;
   logic [CW-1:0] out_env_ff, out_env_in;

   logic [SW-1:0] raw;
   logic [AW-1:0] op_a;
   logic [CW-1:0] op_b;
   logic [CW-1:0] prod_q;
   logic [SW-1:0] prod_s;
   logic [CW-1:0] env_diff;

   // Sign and magnitude of the incoming sample
   assign raw    = req_sample_in;
   assign neg_in = dp_ctrl.item_load ? raw[SW-1] : neg_ff;
   assign mag_in = dp_ctrl.item_load ? (raw[SW-1] ? (~raw + SW'(1)) : raw) : mag_ff;

   // Shared multiplier operand select
   always_comb begin
      op_a = AW'(attack_coeff);
      op_b = OneQ - env_ff;
      case (dp_ctrl.mul_sel)
         MUL_ATTACK:  begin op_a = AW'(attack_coeff);  op_b = OneQ - env_ff; end
         MUL_RELEASE: begin op_a = AW'(release_coeff); op_b = env_ff; end
         MUL_DEPTH:   begin op_a = AW'(duck_depth);    op_b = env_ff; end
         MUL_SAMPLE:  begin op_a = AW'(mag_ff);        op_b = gain_ff; end
         default:     begin op_a = AW'(attack_coeff);  op_b = OneQ - env_ff; end
      endcase
   end

   assign prod_in = dp_ctrl.exec ? (PW'(op_a) * PW'(op_b)) : prod_ff;

   // Product back in Q1.F
   assign prod_q   = CW'(prod_ff >> FRAC_BITS);
   assign prod_s   = SW'(prod_ff >> FRAC_BITS);
   assign env_diff = env_ff - prod_q;

   // Post-multiply update
   always_comb begin
      env_in        = env_ff;
      gain_in       = gain_ff;
      out_sample_in = out_sample_ff;
      out_env_in    = out_env_ff;
      if (dp_ctrl.exec) begin
         case (dp_ctrl.alu_op)
            ALU_ENV_ADD: env_in  = env_ff + prod_q;
            ALU_ENV_SUB: env_in  = (env_diff > OneQ) ? OneQ : env_diff;
            ALU_GAIN:    gain_in = OneQ - prod_q;
            ALU_OUT: begin
               out_sample_in = neg_ff ? (~prod_s + SW'(1)) : prod_s;
               out_env_in    = env_ff;
            end
            default: ;
         endcase
      end
   end

   // Envelope is block state; the rest is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= '0;
      end else begin
         env_ff <= env_in;
      end
   end

   always_ff @(posedge clock) begin
      gain_ff       <= gain_in;
      prod_ff       <= prod_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      out_sample_ff <= out_sample_in;
      out_env_ff    <= out_env_in;
   end

   assign rsp_ducked_sample  = $signed(out_sample_ff);
   assign rsp_envelope_level = out_env_ff;

`ifndef NO_ASSERTIONS
   a_env_in_range: assert property (@(posedge clock) disable iff (reset)
      env_ff <= OneQ)
      else $error("envelope above one");

   a_gain_in_range: assert property (@(posedge clock) disable iff (reset)
      (dp_ctrl.exec && dp_ctrl.alu_op == ALU_GAIN) |=> (gain_ff <= OneQ))
      else $error("gain above one");

   a_out_no_growth: assert property (@(posedge clock) disable iff (reset)
      (dp_ctrl.exec && dp_ctrl.alu_op == ALU_OUT) |-> (prod_s <= mag_ff))
      else $error("scaled magnitude exceeds input magnitude");
`endif

endmodule

// File: hw/rtl/sidechain_ducking_envelope.sv
// Sidechain ducker: one signed sample per beat in, one ducked sample and the
// updated Q1.16 envelope out. Each trigger on the beat pulls the envelope
// toward one by the attack fraction, then the release fraction decays it and
// the sample is scaled by one minus depth times envelope, truncated toward
// zero. The microprogram runs one step per clock, except while held as below,
// on one shared multiplier: two steps per trigger, one step that leaves the
// trigger loop and six for release, gain and output, with the trigger
// count capped at MAX_TRIGGERS. The result beat is registered after the
// output step, and no new beat is taken until the sequencer is back in
// idle. A result still stalled when the next beat reaches its last step
// holds that step until the result is taken. Coefficient writes above one
// saturate to one; writes to an unused index are dropped. Write registers
// only while no beat is in flight.
module sidechain_ducking_envelope
   import sde_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int MAX_TRIGGERS = 3,
   parameter int FRAC_BITS    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic [1:0]                     req_trigger_count,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_ducked_sample,
   output logic [FRAC_BITS:0]             rsp_envelope_level,
   input  logic                           csr_write_enable,
   input  logic [1:0]                     csr_index,
   input  logic [FRAC_BITS:0]             csr_write_data
);

   localparam int CW = FRAC_BITS + 1;
   localparam logic [CW-1:0] OneQ       = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CW-1:0] ReleaseRst = CW'(64);

   logic [CW-1:0] attack_coeff_ff, attack_coeff_in;
   logic [CW-1:0] release_coeff_ff, release_coeff_in;
   logic [CW-1:0] duck_depth_ff, duck_depth_in;
   logic [CW-1:0] csr_sat;
   dp_ctrl_type   dp_ctrl;

   // Coefficient registers, saturated to one on write
   assign csr_sat = (csr_write_data > OneQ) ? OneQ : csr_write_data;

   always_comb begin
      attack_coeff_in  = attack_coeff_ff;
      release_coeff_in = release_coeff_ff;
      duck_depth_in    = duck_depth_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ATTACK_COEFF:  attack_coeff_in  = csr_sat;
            CSR_RELEASE_COEFF: release_coeff_in = csr_sat;
            CSR_DUCK_DEPTH:    duck_depth_in    = csr_sat;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_coeff_ff  <= OneQ;
         release_coeff_ff <= ReleaseRst;
         duck_depth_ff    <= OneQ;
      end else begin
         attack_coeff_ff  <= attack_coeff_in;
         release_coeff_ff <= release_coeff_in;
         duck_depth_ff    <= duck_depth_in;
      end
   end

   sde_ucode_seq #(
      .MAX_TRIGGERS(MAX_TRIGGERS)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_trigger_count (req_trigger_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .dp_ctrl           (dp_ctrl)
   );

   sde_datapath #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .dp_ctrl            (dp_ctrl),
      .req_sample_in      (req_sample_in),
      .attack_coeff       (attack_coeff_ff),
      .release_coeff      (release_coeff_ff),
      .duck_depth         (duck_depth_ff),
      .rsp_ducked_sample  (rsp_ducked_sample),
      .rsp_envelope_level (rsp_envelope_level)
   );

`ifndef NO_ASSERTIONS
   a_attack_sat: assert property (@(posedge clock) disable iff (reset)
      attack_coeff_ff <= OneQ)
      else $error("attack coefficient above one");

   a_release_sat: assert property (@(posedge clock) disable iff (reset)
      release_coeff_ff <= OneQ)
      else $error("release coefficient above one");

   a_depth_sat: assert property (@(posedge clock) disable iff (reset)
      duck_depth_ff <= OneQ)
      else $error("depth above one");
`endif

endmodule
